// ===== rtl/rngl_pkg.sv =====
// rngl_pkg: shared types and constants of the run n-gram segment labeler.
// Depends on nothing; imported by rngl_window, rngl_match and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rngl_pkg;

    localparam int SYM_W      = 16;
    localparam int FRAME_W    = 32;
    localparam int ORDER_W    = 3;
    localparam int SIZE_W     = 5;
    localparam int TAG_W      = 5;
    localparam int ROW_W      = 4;
    localparam int POS_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_NGRAM_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 1'b1;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 5'd16;

    localparam logic CMD_LABEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_GAP   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAIL_CHK,
        ST_DROP,
        ST_PLACE,
        ST_LOOK,
        ST_GAP,
        ST_HIT,
        ST_SHIFT,
        ST_AFTER,
        ST_TRAIL,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RD,
        M_CMP
    } t_match_state;

    typedef struct packed {
        logic                     clear;
        logic                     drop;
        logic                     place;
        logic signed [SYM_W-1:0]  sym;
        logic [FRAME_W-1:0]       start;
    } t_win_ctl;

    typedef struct packed {
        logic               start;
        logic [ORDER_W-1:0] ord;
        logic [SIZE_W-1:0]  entries;
    } t_match_req;

    typedef struct packed {
        logic             done;
        logic [TAG_W-1:0] tag;
    } t_match_st;

    typedef struct packed {
        logic               kind;
        logic [TAG_W-1:0]   tag;
        logic [FRAME_W-1:0] seg_begin;
        logic [FRAME_W-1:0] seg_length;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rngl_ram.sv =====
// rngl_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rngl_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/rngl_window.sv =====
// rngl_window: sliding window of closed runs (symbol and start frame) and fill count.
// Depends on rngl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rngl_window
    import rngl_pkg::*;
#(
    parameter int MAX_ORDER = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_win_ctl                 i_ctl,
    input  wire logic [ORDER_W-1:0]       i_rd_idx,
    output logic signed [SYM_W-1:0]       o_rd_sym,
    output logic [FRAME_W-1:0]            o_start0,
    output logic [ORDER_W-1:0]            o_filled
);

    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    logic signed [SYM_W-1:0] r_sym   [MAX_ORDER];
    logic [FRAME_W-1:0]      r_start [MAX_ORDER];
    logic [ORDER_W-1:0]      r_filled;
    logic [ORDER_W-1:0]      n_filled;

    always_comb begin
        n_filled = r_filled;
        if (i_ctl.clear) begin
            n_filled = '0;
        end else if (i_ctl.drop) begin
            if (r_filled != '0) begin
                n_filled = r_filled - ORDER_W'(1);
            end
        end else if (i_ctl.place) begin
            n_filled = r_filled + ORDER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else begin
            r_filled <= n_filled;
        end
        if (i_ctl.drop) begin
            for (int i = 0; i < MAX_ORDER - 1; i++) begin
                r_sym[i]   <= r_sym[i + 1];
                r_start[i] <= r_start[i + 1];
            end
        end else if (i_ctl.place) begin
            r_sym[IW'(r_filled)]   <= i_ctl.sym;
            r_start[IW'(r_filled)] <= i_ctl.start;
        end
    end

    assign o_rd_sym = r_sym[IW'(i_rd_idx)];
    assign o_start0 = r_start[0];
    assign o_filled = r_filled;

endmodule

`default_nettype wire

// ===== rtl/rngl_match.sv =====
// rngl_match: walks the n-gram table in RAM, one symbol per read, first hit wins.
// Depends on rngl_pkg; drives the read port of the table RAM.
`timescale 1ns / 1ps
`default_nettype none

module rngl_match
    import rngl_pkg::*;
#(
    parameter int MAX_ORDER = 4,
    parameter int ADDR_W    = 6
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_match_req              i_req,
    input  wire logic signed [SYM_W-1:0] i_win_sym,
    output logic [ORDER_W-1:0]           o_win_idx,
    output logic                         o_ram_re,
    output logic [ADDR_W-1:0]            o_ram_raddr,
    input  wire logic [SYM_W-1:0]        i_ram_rdata,
    output t_match_st                    o_st
);

    localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_ORDER);

    t_match_state       r_mstate, n_mstate;
    logic [SIZE_W-1:0]  r_e, n_e;
    logic [ORDER_W-1:0] r_s, n_s;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [ORDER_W-1:0] r_ord, n_ord;
    logic [SIZE_W-1:0]  r_n, n_n;
    logic               r_done, n_done;
    logic [TAG_W-1:0]   r_tag, n_tag;

    always_comb begin
        n_mstate = r_mstate;
        n_e      = r_e;
        n_s      = r_s;
        n_base   = r_base;
        n_ord    = r_ord;
        n_n      = r_n;
        n_done   = 1'b0;
        n_tag    = r_tag;
        o_ram_re = 1'b0;
        case (r_mstate)
            M_IDLE: begin
                if (i_req.start) begin
                    n_ord  = i_req.ord;
                    n_n    = i_req.entries;
                    n_e    = '0;
                    n_s    = '0;
                    n_base = '0;
                    if (i_req.entries == '0) begin
                        n_done = 1'b1;
                        n_tag  = '0;
                    end else begin
                        n_mstate = M_RD;
                    end
                end
            end
            M_RD: begin
                o_ram_re = 1'b1;
                n_mstate = M_CMP;
            end
            M_CMP: begin
                if (i_ram_rdata == $unsigned(i_win_sym)) begin
                    if ((r_s + ORDER_W'(1)) == r_ord) begin
                        n_done   = 1'b1;
                        n_tag    = TAG_W'(r_e + SIZE_W'(1));
                        n_mstate = M_IDLE;
                    end else begin
                        n_s      = r_s + ORDER_W'(1);
                        n_mstate = M_RD;
                    end
                end else if ((r_e + SIZE_W'(1)) == r_n) begin
                    n_done   = 1'b1;
                    n_tag    = '0;
                    n_mstate = M_IDLE;
                end else begin
                    n_e      = r_e + SIZE_W'(1);
                    n_s      = '0;
                    n_base   = r_base + STRIDE;
                    n_mstate = M_RD;
                end
            end
            default: begin
                n_mstate = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate <= M_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_mstate <= n_mstate;
            r_done   <= n_done;
        end
        r_e    <= n_e;
        r_s    <= n_s;
        r_base <= n_base;
        r_ord  <= n_ord;
        r_n    <= n_n;
        r_tag  <= n_tag;
    end

    assign o_win_idx   = r_s;
    assign o_ram_raddr = r_base + ADDR_W'(r_s);
    assign o_st.done   = r_done;
    assign o_st.tag    = r_tag;

endmodule

`default_nettype wire

// ===== rtl/run_ngram_segment_labeler_core.sv =====
// run_ngram_segment_labeler_core: top level; run tracking, gap spans, output stage.
// Depends on rngl_pkg, rngl_ram, rngl_window, rngl_match.
//
// Input stream (s_axis): one beat per label frame or per table write. tuser selects
// the command (label frame / write table symbol), tlast marks the last frame of a
// segment. Output stream (m_axis): one beat per span, tuser = kind (match / oov gap),
// tlast on the last span caused by an input beat.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_addr (0 = ngram_order,
// 1 = table_size); write only while the block is idle.
// Sequence: a table write is taken in idle. A label beat with no closing run steps
// through accept, tail check and flush. Each closed run drops the oldest runs while
// the window is full and places the new one; once the window is full again, a table
// walk follows, then a matched span (with a pending gap span ahead of it) or a miss,
// then a window shift; the walk reads stored symbols through the RAM read port.
// Spans are held in a one-deep hold register ahead of the output register, so the
// last flag is known before a span leaves; the block takes no new beat until all
// spans of the current beat are in the output register.
// Reset: no segment open, window empty, config at ngram_order 3 and table_size 16;
// the table RAM is not cleared and must be written before use.
// A stalled receiver holds m_axis and stalls the sequencer at the next span.
`timescale 1ns / 1ps
`default_nettype none

module run_ngram_segment_labeler_core
    import rngl_pkg::*;
#(
    parameter int MAX_ORDER   = 4,
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // symbol[15:0], frame_index[47:16], table_row[51:48], table_position[53:52]
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // command
    input  wire logic                    s_axis_tuser,
    input  wire logic                    s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tag[4:0], seg_begin[36:5], seg_length[68:37]
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
    // kind
    output logic                         m_axis_tuser,
    output logic                         m_axis_tlast,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int RAM_DEPTH = TABLE_DEPTH * MAX_ORDER;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int ORD_CAP   = (MAX_ORDER > 7) ? 7 : MAX_ORDER;
    localparam int SIZE_CAP  = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;
    localparam logic [ORDER_W-1:0] ORD_CAP_V  = ORDER_W'(ORD_CAP);
    localparam logic [SIZE_W-1:0]  SIZE_CAP_V = SIZE_W'(SIZE_CAP);

    // input beat fields
    logic                    in_cmd;
    logic signed [SYM_W-1:0] in_sym;
    logic [FRAME_W-1:0]      in_frame;
    logic [ROW_W-1:0]        in_row;
    logic [POS_W-1:0]        in_pos;
    logic                    in_accept;

    assign in_cmd    = s_axis_tuser;
    assign in_sym    = s_axis_tdata[15:0];
    assign in_frame  = s_axis_tdata[47:16];
    assign in_row    = s_axis_tdata[51:48];
    assign in_pos    = s_axis_tdata[53:52];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // config registers
    logic [ORDER_W-1:0] r_ngram_order;
    logic [SIZE_W-1:0]  r_table_size;
    logic [ORDER_W-1:0] eff_ord;
    logic [SIZE_W-1:0]  eff_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ngram_order <= ORDER_RESET;
            r_table_size  <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NGRAM_ORDER: r_ngram_order <= i_cfg_data[ORDER_W-1:0];
                CFG_TABLE_SIZE:  r_table_size  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_ngram_order == '0) begin
            eff_ord = ORDER_W'(1);
        end else if (r_ngram_order > ORD_CAP_V) begin
            eff_ord = ORD_CAP_V;
        end else begin
            eff_ord = r_ngram_order;
        end
        eff_size = (r_table_size > SIZE_CAP_V) ? SIZE_CAP_V : r_table_size;
    end

    // table RAM write
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SYM_W-1:0]  ram_rdata;

    assign ram_we = in_accept && (in_cmd == CMD_WRITE)
                    && (32'(in_row) < 32'(TABLE_DEPTH))
                    && (32'(in_pos) < 32'(MAX_ORDER));
    assign ram_waddr = ADDR_W'(32'(in_row) * 32'(MAX_ORDER) + 32'(in_pos));

    // sequencer state
    t_state                  r_state, n_state;
    logic                    r_run_open, n_run_open;
    logic signed [SYM_W-1:0] r_run_label, n_run_label;
    logic [FRAME_W-1:0]      r_run_start, n_run_start;
    logic                    r_gap_pending, n_gap_pending;
    logic [FRAME_W-1:0]      r_gap_start, n_gap_start;
    logic [FRAME_W-1:0]      r_prev_frame, n_prev_frame;
    logic signed [SYM_W-1:0] r_sym, n_sym;
    logic [FRAME_W-1:0]      r_frame, n_frame;
    logic                    r_seg_last, n_seg_last;
    logic [FRAME_W-1:0]      r_stop, n_stop;
    logic                    r_final, n_final;
    logic [TAG_W-1:0]        r_tag, n_tag;
    t_result                 r_hold, n_hold;
    logic                    r_hold_valid, n_hold_valid;
    t_result                 r_out, n_out;
    logic                    r_out_last, n_out_last;
    logic                    r_out_valid, n_out_valid;

    t_win_ctl                win_ctl;
    logic signed [SYM_W-1:0] win_sym;
    logic [FRAME_W-1:0]      win_start0;
    logic [ORDER_W-1:0]      win_filled;
    logic [ORDER_W-1:0]      win_idx;
    t_match_req              m_req;
    t_match_st               m_st;

    logic    out_free;
    logic    can_push;
    logic    push;
    logic    flush;
    t_result push_res;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign can_push      = !r_hold_valid || out_free;
    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        n_run_open    = r_run_open;
        n_run_label   = r_run_label;
        n_run_start   = r_run_start;
        n_gap_pending = r_gap_pending;
        n_gap_start   = r_gap_start;
        n_prev_frame  = r_prev_frame;
        n_sym         = r_sym;
        n_frame       = r_frame;
        n_seg_last    = r_seg_last;
        n_stop        = r_stop;
        n_final       = r_final;
        n_tag         = r_tag;
        win_ctl       = '{clear: 1'b0, drop: 1'b0, place: 1'b0,
                          sym: r_run_label, start: r_run_start};
        m_req         = '{start: 1'b0, ord: eff_ord, entries: eff_size};
        push          = 1'b0;
        flush         = 1'b0;
        push_res      = '{kind: KIND_GAP, tag: '0, seg_begin: r_gap_start,
                          seg_length: win_start0 - r_gap_start};

        case (r_state)
            ST_IDLE: begin
                if (in_accept && (in_cmd == CMD_LABEL)) begin
                    n_sym        = in_sym;
                    n_frame      = in_frame;
                    n_seg_last   = s_axis_tlast;
                    n_prev_frame = in_frame;
                    if (!r_run_open) begin
                        n_run_open    = 1'b1;
                        n_run_label   = in_sym;
                        n_run_start   = in_frame;
                        n_gap_start   = in_frame;
                        n_gap_pending = 1'b1;
                        win_ctl.clear = 1'b1;
                        n_state       = ST_TAIL_CHK;
                    end else if (in_sym != r_run_label) begin
                        n_stop  = r_prev_frame;
                        n_final = 1'b0;
                        n_state = ST_DROP;
                    end else begin
                        n_state = ST_TAIL_CHK;
                    end
                end
            end
            ST_TAIL_CHK: begin
                if (r_seg_last) begin
                    n_stop  = r_frame;
                    n_final = 1'b1;
                    n_state = ST_DROP;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_DROP: begin
                if (win_filled >= eff_ord) begin
                    win_ctl.drop = 1'b1;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                win_ctl.place = 1'b1;
                if ((win_filled + ORDER_W'(1)) < eff_ord) begin
                    n_state = r_final ? ST_TRAIL : ST_AFTER;
                end else begin
                    m_req.start = 1'b1;
                    n_state     = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (m_st.done) begin
                    if (m_st.tag != '0) begin
                        n_tag   = m_st.tag;
                        n_state = (r_gap_pending && (r_gap_start < win_start0))
                                  ? ST_GAP : ST_HIT;
                    end else begin
                        n_gap_pending = 1'b1;
                        n_state       = ST_SHIFT;
                    end
                end
            end
            ST_GAP: begin
                if (can_push) begin
                    push    = 1'b1;
                    n_state = ST_HIT;
                end
            end
            ST_HIT: begin
                push_res = '{kind: KIND_MATCH, tag: r_tag, seg_begin: win_start0,
                             seg_length: r_stop - win_start0 + FRAME_W'(1)};
                if (can_push) begin
                    push          = 1'b1;
                    n_gap_start   = r_stop + FRAME_W'(1);
                    n_gap_pending = 1'b0;
                    n_state       = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                win_ctl.drop = 1'b1;
                n_state      = r_final ? ST_TRAIL : ST_AFTER;
            end
            ST_AFTER: begin
                n_run_label = r_sym;
                n_run_start = r_frame;
                n_state     = ST_TAIL_CHK;
            end
            ST_TRAIL: begin
                push_res = '{kind: KIND_GAP, tag: '0, seg_begin: r_gap_start,
                             seg_length: r_frame + FRAME_W'(1) - r_gap_start};
                if (!r_gap_pending) begin
                    n_run_open = 1'b0;
                    n_state    = ST_FLUSH;
                end else if (can_push) begin
                    push       = 1'b1;
                    n_run_open = 1'b0;
                    n_state    = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    flush   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hold register feeds the output register
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        if (push) begin
            if (r_hold_valid) begin
                n_out       = r_hold;
                n_out_last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_hold       = push_res;
            n_hold_valid = 1'b1;
        end else if (flush) begin
            n_out        = r_hold;
            n_out_last   = 1'b1;
            n_out_valid  = 1'b1;
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_run_open    <= 1'b0;
            r_gap_pending <= 1'b1;
            r_hold_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_run_open    <= n_run_open;
            r_gap_pending <= n_gap_pending;
            r_hold_valid  <= n_hold_valid;
            r_out_valid   <= n_out_valid;
        end
        r_run_label  <= n_run_label;
        r_run_start  <= n_run_start;
        r_gap_start  <= n_gap_start;
        r_prev_frame <= n_prev_frame;
        r_sym        <= n_sym;
        r_frame      <= n_frame;
        r_seg_last   <= n_seg_last;
        r_stop       <= n_stop;
        r_final      <= n_final;
        r_tag        <= n_tag;
        r_hold       <= n_hold;
        r_out        <= n_out;
        r_out_last   <= n_out_last;
    end

    // table writes happen only in idle, walks only in ST_LOOK: no overlap on the RAM
    rngl_ram #(
        .WIDTH  (SYM_W),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_sym),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rngl_window #(
        .MAX_ORDER (MAX_ORDER)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (win_ctl),
        .i_rd_idx (win_idx),
        .o_rd_sym (win_sym),
        .o_start0 (win_start0),
        .o_filled (win_filled)
    );

    rngl_match #(
        .MAX_ORDER (MAX_ORDER),
        .ADDR_W    (ADDR_W)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (m_req),
        .i_win_sym   (win_sym),
        .o_win_idx   (win_idx),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_st        (m_st)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {3'b000, r_out.seg_length, r_out.seg_begin, r_out.tag};

    a_done_in_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_st.done |-> r_state == ST_LOOK)
        else $error("table walk finished outside lookup wait");

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_hold_valid)
        else $error("span left in hold register while idle");

    a_match_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid && r_hold.kind == KIND_MATCH |-> r_hold.tag != '0)
        else $error("matched span with zero tag");

    a_hit_clears_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HIT && can_push |=> !r_gap_pending)
        else $error("gap still pending after a matched span");

    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_cmd == CMD_WRITE |=> r_state == ST_IDLE)
        else $error("table write left the idle state");

endmodule

`default_nettype wire
